// ===== hw/rtl/mssd_pkg.sv =====
// Shared types and constants for the multiplexed seven-segment driver.
`timescale 1ns / 1ps
`default_nettype none

package mssd_pkg;

  // Geometry
  localparam int DIGITS    = 4;
  localparam int POS_W     = $clog2(DIGITS);
  localparam int CODE_W    = 4;
  localparam int SEG_W     = 8;
  localparam int TICK_W    = 8;
  localparam int PCT_W     = 7;
  localparam int NUMBER_W  = 16;
  localparam int BIN_W     = 14;   // holds 0..9999
  localparam int PROD_W    = PCT_W + TICK_W + 1;
  localparam int PIDX_W    = 3;

  // Input and output stream widths
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Request kinds carried on tuser
  typedef enum logic [IN_USER_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_DIGIT  = 2'd2,
    MODE_POINT  = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_TOP   = 1'b1;

  // Reset values and limits
  localparam logic [PCT_W-1:0]  PCT_MIN       = 7'd5;
  localparam logic [PCT_W-1:0]  PCT_MAX       = 7'd100;
  localparam logic [TICK_W-1:0] TOP_RESET     = 8'd49;
  localparam logic [PIDX_W-1:0] POINT_OFF     = 3'd7;
  localparam logic [CODE_W-1:0] ERR_CODE      = 4'd14;
  localparam logic [SEG_W-1:0]  SEG_ALL_OFF   = 8'hFF;
  localparam logic [DIGITS-1:0] ENABLE_RESET  = 4'b0001;
  localparam int                POINT_BIT     = 5;
  localparam logic [3:0]        POINT_POS_OFF = 4'hF;
  localparam logic [BIN_W-1:0]  NUMBER_MAX    = 14'd9999;

  // Reciprocal multipliers for constant division (exact over the used range)
  localparam logic [15:0] RECIP_10   = 16'd52429;  // >> 19
  localparam logic [12:0] RECIP_100  = 13'd5243;   // >> 19
  localparam logic [13:0] RECIP_1000 = 14'd8389;   // >> 23

  // Glyph patterns, active high, indexed by digit code
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] pat;
    case (code)
      4'd0:    pat = 8'd215;
      4'd1:    pat = 8'd17;
      4'd2:    pat = 8'd143;
      4'd3:    pat = 8'd155;
      4'd4:    pat = 8'd89;
      4'd5:    pat = 8'd218;
      4'd6:    pat = 8'd222;
      4'd7:    pat = 8'd145;
      4'd8:    pat = 8'd223;
      4'd9:    pat = 8'd219;
      4'd10:   pat = 8'd221;
      4'd11:   pat = 8'd94;
      4'd12:   pat = 8'd198;
      4'd13:   pat = 8'd31;
      4'd14:   pat = 8'd206;
      default: pat = 8'd204;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/multiplexed_seven_segment_driver_unit.sv =====
// Four-digit multiplexed seven-segment driver with PWM dimming.
// A request is registered in stage A, and its result is then held in the output register.
// Throughput: one request per cycle while the output stream is not stalled; the pre-divide
//   and state-update stages are registered, and backpressure reaches s_tready combinationally.
// Reset (rst, synchronous, active high): digit codes 0, point off, position 0,
//   segments all off, digit 0 enabled, brightness 5% (the minimum), top 49.
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_seven_segment_driver_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  // Input stream
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // tdata: number[15:0], digit_pos[17:16], digit_code[21:18], point_pos[25:22], zeros
  input  wire  [mssd_pkg::IN_DATA_W-1:0]       s_tdata,
  // tuser: mode[1:0]
  input  wire  [mssd_pkg::IN_USER_W-1:0]       s_tuser,
  // Output stream
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // tdata: segments[7:0], digit_enable[11:8], zeros
  output logic [mssd_pkg::OUT_DATA_W-1:0]      m_tdata,
  // Configuration writes
  input  wire                                  cfg_we,
  input  wire  [mssd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [mssd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mssd_pkg::*;

  // Configuration: clamped percent, top and their product
  logic [PCT_W-1:0]  pct;
  logic [TICK_W-1:0] top;
  logic [PROD_W-1:0] duty_prod;
  logic [PCT_W-1:0]  wr_pct;

  always_comb begin
    wr_pct = cfg_data[PCT_W-1:0];
    if (wr_pct < PCT_MIN) wr_pct = PCT_MIN;
    else if (wr_pct > PCT_MAX) wr_pct = PCT_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pct       <= PCT_MIN;
      top       <= TOP_RESET;
      duty_prod <= PROD_W'(PCT_MIN) * PROD_W'(TOP_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BRIGHTNESS: begin
          pct       <= wr_pct;
          duty_prod <= PROD_W'(wr_pct) * PROD_W'(top);
        end
        CFG_SCAN_TOP: begin
          top       <= cfg_data;
          duty_prod <= PROD_W'(pct) * PROD_W'(cfg_data);
        end
        default: ;
      endcase
    end
  end

  // Stage A: register the request with its decimal quotients
  logic [BIN_W-1:0] in_bin;
  logic [29:0]      div10_prod;
  logic [27:0]      div100_prod;
  logic [27:0]      div1000_prod;
  logic             in_bad;

  assign in_bin       = s_tdata[BIN_W-1:0];
  assign div10_prod   = 30'(in_bin) * 30'(RECIP_10);
  assign div100_prod  = 28'(in_bin) * 28'(RECIP_100);
  assign div1000_prod = 28'(in_bin) * 28'(RECIP_1000);
  assign in_bad       = s_tdata[NUMBER_W-1] || (s_tdata[NUMBER_W-2:BIN_W] != '0)
                        || (in_bin > NUMBER_MAX);

  logic              a_valid;
  mode_t             a_mode;
  logic              a_bad;
  logic [BIN_W-1:0]  a_bin;
  logic [9:0]        a_q10;
  logic [6:0]        a_q100;
  logic [3:0]        a_q1000;
  logic [POS_W-1:0]  a_pos;
  logic [CODE_W-1:0] a_code;
  logic [3:0]        a_point;
  logic              a_advance;

  assign a_advance = a_valid && (!m_tvalid || m_tready);
  assign s_tready  = !a_valid || a_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      a_mode  <= mode_t'(s_tuser);
      a_bad   <= in_bad;
      a_bin   <= in_bin;
      a_q10   <= div10_prod[28:19];
      a_q100  <= div100_prod[25:19];
      a_q1000 <= div1000_prod[26:23];
      a_pos   <= s_tdata[17:16];
      a_code  <= s_tdata[21:18];
      a_point <= s_tdata[25:22];
    end
  end

  // Display state
  logic [CODE_W-1:0] digit_codes [DIGITS];
  logic [POS_W-1:0]  active_position;
  logic [PIDX_W-1:0] point_index;
  logic [TICK_W-1:0] tick_count;
  logic [SEG_W-1:0]  segment_latch;
  logic [DIGITS-1:0] enable_latch;

  // Compare value: floor(pct*top/100) - 1, floored at zero
  logic [27:0]       cmp_prod;
  logic [TICK_W-1:0] cmp_quot;
  logic [TICK_W-1:0] cmp_value;

  assign cmp_prod  = 28'(duty_prod) * 28'(RECIP_100);
  assign cmp_quot  = cmp_prod[26:19];
  assign cmp_value = (cmp_quot == '0) ? '0 : cmp_quot - 1'b1;

  // Decimal digits from the registered quotients
  logic [6:0]        rem1;
  logic [9:0]        rem2;
  logic [BIN_W-1:0]  rem3;
  logic [CODE_W-1:0] dec [DIGITS];

  always_comb begin
    rem1   = a_q100 - 7'(a_q1000 * 7'd10);
    rem2   = a_q10 - 10'(a_q100 * 10'd10);
    rem3   = a_bin - BIN_W'(a_q10 * BIN_W'(10));
    dec[0] = a_q1000;
    dec[1] = rem1[CODE_W-1:0];
    dec[2] = rem2[CODE_W-1:0];
    dec[3] = rem3[CODE_W-1:0];
  end

  // Next state for the request in stage A
  logic [CODE_W-1:0] digit_codes_next [DIGITS];
  logic [POS_W-1:0]  active_position_next;
  logic [PIDX_W-1:0] point_index_next;
  logic [TICK_W-1:0] tick_count_next;
  logic [SEG_W-1:0]  segment_latch_next;
  logic [DIGITS-1:0] enable_latch_next;
  logic [POS_W-1:0]  nxt_pos;
  logic [SEG_W-1:0]  nxt_pat;

  always_comb begin
    digit_codes_next     = digit_codes;
    active_position_next = active_position;
    point_index_next     = point_index;
    tick_count_next      = tick_count;
    segment_latch_next   = segment_latch;
    enable_latch_next    = enable_latch;
    nxt_pos              = active_position + 1'b1;
    nxt_pat              = seg_pattern(digit_codes[nxt_pos]);
    if (point_index == PIDX_W'(nxt_pos)) nxt_pat[POINT_BIT] = 1'b1;

    unique case (a_mode)
      MODE_TICK: begin
        // blank first; a wrap on the same tick relights
        if (tick_count == cmp_value) enable_latch_next = '0;
        if (tick_count >= top) begin
          tick_count_next      = '0;
          active_position_next = nxt_pos;
          segment_latch_next   = ~nxt_pat;
          enable_latch_next    = DIGITS'(1) << nxt_pos;
        end else begin
          tick_count_next = tick_count + 1'b1;
        end
      end
      MODE_NUMBER: begin
        for (int i = 0; i < DIGITS; i++) begin
          digit_codes_next[i] = a_bad ? ERR_CODE : dec[i];
        end
      end
      MODE_DIGIT: begin
        digit_codes_next[a_pos] = a_code;
      end
      MODE_POINT: begin
        // place counted from the right; other places leave it alone
        if (a_point[3:2] == 2'b00) point_index_next = PIDX_W'(2'd3 - a_point[1:0]);
        else if (a_point == POINT_POS_OFF) point_index_next = POINT_OFF;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIGITS; i++) digit_codes[i] <= '0;
      active_position <= '0;
      point_index     <= POINT_OFF;
      tick_count      <= '0;
      segment_latch   <= SEG_ALL_OFF;
      enable_latch    <= ENABLE_RESET;
    end else if (a_advance) begin
      digit_codes     <= digit_codes_next;
      active_position <= active_position_next;
      point_index     <= point_index_next;
      tick_count      <= tick_count_next;
      segment_latch   <= segment_latch_next;
      enable_latch    <= enable_latch_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (a_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (a_advance) begin
      m_tdata <= {(OUT_DATA_W - SEG_W - DIGITS)'(0), enable_latch_next, segment_latch_next};
    end
  end

  // Checks
  a_enable_onehot0: assert property (@(posedge clk) disable iff (rst)
    $onehot0(enable_latch))
    else $error("digit enable has more than one bit set");

  a_point_legal: assert property (@(posedge clk) disable iff (rst)
    point_index <= PIDX_W'(DIGITS - 1) || point_index == POINT_OFF)
    else $error("point index holds an unused value");

  a_wrap_clears: assert property (@(posedge clk) disable iff (rst)
    a_advance && a_mode == MODE_TICK && tick_count >= top |=> tick_count == '0)
    else $error("tick counter did not wrap");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> a_valid && m_tvalid && !m_tready)
    else $error("input stalled without a full pipeline");

  a_write_holds_display: assert property (@(posedge clk) disable iff (rst)
    a_advance && a_mode != MODE_TICK |=> $stable(segment_latch) && $stable(enable_latch))
    else $error("content write changed the display latches");

endmodule

`default_nettype wire

// ===== tb/tb_multiplexed_seven_segment_driver_unit.sv =====
// Self-checking testbench for the multiplexed seven-segment driver unit.
`timescale 1ns / 1ps

module tb_multiplexed_seven_segment_driver_unit;
  import mssd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_ROWS    = 24;
  localparam int SETTINGS_N  = 10;
  localparam int PHASE_ITEMS = 52;
  localparam int HOLD_CYCLES = 100;
  localparam int QUIET_GAP   = 4;

  // Glyphs, code 15 in the top byte down to code 0 in the bottom byte
  localparam logic [16*SEG_W-1:0] GLYPHS = {
    8'd204, 8'd206, 8'd31,  8'd198, 8'd94,  8'd221, 8'd219, 8'd223,
    8'd145, 8'd222, 8'd218, 8'd89,  8'd155, 8'd143, 8'd17,  8'd215
  };

  typedef struct packed {
    mode_t             mode;
    logic [15:0]       number;
    logic [POS_W-1:0]  dpos;
    logic [CODE_W-1:0] dcode;
    logic [3:0]        ppos;
  } req_t;

  typedef struct packed {
    logic [SEG_W-1:0]  seg;
    logic [DIGITS-1:0] en;
  } disp_t;

  typedef struct packed {
    req_t  req;
    bit    typed;
    disp_t want;
  } row_t;

  localparam disp_t START_VIEW = '{SEG_ALL_OFF, ENABLE_RESET};
  localparam disp_t NO_VIEW    = '{8'h00, 4'h0};

  // DUT ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  multiplexed_seven_segment_driver_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the display state
  logic [CODE_W-1:0] shown_codes [DIGITS];
  logic [POS_W-1:0]  scan_pos;
  logic [PIDX_W-1:0] point_idx;
  logic [TICK_W-1:0] tick_cnt;
  logic [SEG_W-1:0]  seg_latch;
  logic [DIGITS-1:0] en_latch;
  logic [PCT_W-1:0]  pct_reg;
  logic [TICK_W-1:0] top_reg;

  disp_t pending_views [$];
  disp_t seen_view;
  int    errors = 0;
  int    checked = 0;
  int    cycles = 0;
  int    n_ticks = 0;
  int    n_writes = 0;
  int    n_scans = 0;
  bit    calm = 1'b0;
  bit    offering = 1'b0;
  row_t  plan [DIR_ROWS];

  // Blank point of the PWM: clamped duty times top over 100, minus one
  function automatic int duty_compare();
    int p;
    int c;
    p = pct_reg;
    if (p < 5) p = 5;
    if (p > 100) p = 100;
    c = (p * top_reg) / 100;
    return (c > 0) ? c - 1 : 0;
  endfunction

  // Advance the shadow state by one request and return the latched view
  task automatic step_display(input req_t r, output disp_t view);
    logic signed [15:0] num;
    logic [POS_W-1:0]   nxt;
    logic [SEG_W-1:0]   pat;
    int                 v;
    case (r.mode)
      MODE_TICK: begin
        n_ticks++;
        if (int'(tick_cnt) == duty_compare()) en_latch = '0;
        if (tick_cnt >= top_reg) begin
          tick_cnt = '0;
          nxt = scan_pos + 1'b1;
          pat = GLYPHS[shown_codes[nxt]*SEG_W +: SEG_W];
          if (point_idx == {1'b0, nxt}) pat[POINT_BIT] = 1'b1;
          seg_latch = ~pat;
          scan_pos = nxt;
          en_latch = DIGITS'(1) << nxt;
          n_scans++;
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end
      MODE_NUMBER: begin
        n_writes++;
        num = r.number;
        if (num < 0 || num > 9999) begin
          for (int i = 0; i < DIGITS; i++) shown_codes[i] = ERR_CODE;
        end else begin
          v = num;
          for (int i = DIGITS - 1; i >= 0; i--) begin
            shown_codes[i] = CODE_W'(v % 10);
            v = v / 10;
          end
        end
      end
      MODE_DIGIT: begin
        n_writes++;
        shown_codes[r.dpos] = r.dcode;
      end
      default: begin
        n_writes++;
        if (r.ppos <= 4'd3) point_idx = PIDX_W'(3 - r.ppos);
        else if (r.ppos == POINT_POS_OFF) point_idx = POINT_OFF;
      end
    endcase
    view = '{seg_latch, en_latch};
  endtask

  // Offer one request, predict on acceptance, then maybe pause
  task automatic offer_request(input req_t r, input bit typed, input disp_t want);
    disp_t view;
    int    gap;
    s_tvalid <= 1'b1;
    s_tuser  <= r.mode;
    s_tdata  <= {6'd0, r.ppos, r.dcode, r.dpos, r.number};
    offering = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    step_display(r, view);
    pending_views.push_back(typed ? want : view);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly scan ticks, with content writes carrying random payloads
  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick    = $urandom_range(0, 99);
    r.number = 16'($urandom);
    r.dpos   = POS_W'($urandom);
    r.dcode  = CODE_W'($urandom);
    r.ppos   = 4'($urandom);
    if (pick < 68) begin
      r.mode = MODE_TICK;
    end else if (pick < 78) begin
      r.mode = MODE_NUMBER;
      if ($urandom_range(0, 2) != 0) r.number = 16'($urandom_range(0, 9999));
    end else if (pick < 89) begin
      r.mode = MODE_DIGIT;
    end else begin
      r.mode = MODE_POINT;
      if ($urandom_range(0, 3) != 0) r.ppos = 4'($urandom_range(0, 3));
    end
    return r;
  endfunction

  task automatic write_settings(input logic [7:0] pct, input logic [7:0] top);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BRIGHTNESS;
    cfg_data  <= pct;
    @(posedge clk);
    pct_reg = pct[PCT_W-1:0];
    cfg_index <= CFG_SCAN_TOP;
    cfg_data  <= top;
    @(posedge clk);
    top_reg = top;
    cfg_we <= 1'b0;
  endtask

  task automatic drain_results();
    if (offering) s_tvalid <= 1'b0;
    offering = 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (QUIET_GAP) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      checked <= checked + 1;
      if (pending_views.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: seg=%h en=%b", m_tdata[7:0], m_tdata[11:8]);
      end else begin
        seen_view = pending_views.pop_front();
        if (m_tdata[7:0] !== seen_view.seg || m_tdata[11:8] !== seen_view.en) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: expected seg=%h en=%b, got seg=%h en=%b",
                     checked, seen_view.seg, seen_view.en, m_tdata[7:0], m_tdata[11:8]);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("multiplexed_seven_segment_driver_unit: mismatch");
      $finish;
    end
  end

  // Result side: short random stalls, one long hold while requests keep coming
  initial begin : result_sink
    int  stall;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && checked >= 150 && s_tvalid) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 9) < 2) begin
        stall = $urandom_range(1, 6);
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Main sequence
  initial begin : stimulus
    logic [7:0] pct_set [SETTINGS_N];
    logic [7:0] top_set [SETTINGS_N];
    // point writes cover off, both ends, and the ignored places 4, 7, -8, -2
    plan = '{
      '{'{MODE_NUMBER, 16'd0,     2'd0, 4'd0,  4'd0}, 1'b1, START_VIEW},
      '{'{MODE_NUMBER, 16'd9999,  2'd1, 4'd5,  4'd1}, 1'b1, START_VIEW},
      '{'{MODE_NUMBER, 16'hFFFF,  2'd0, 4'd0,  4'd0}, 1'b1, START_VIEW},
      '{'{MODE_NUMBER, 16'd10000, 2'd0, 4'd0,  4'd0}, 1'b1, START_VIEW},
      '{'{MODE_NUMBER, 16'h8000,  2'd0, 4'd0,  4'd0}, 1'b1, START_VIEW},
      '{'{MODE_NUMBER, 16'h7FFF,  2'd3, 4'hF,  4'hF}, 1'b1, START_VIEW},
      '{'{MODE_NUMBER, 16'd1234,  2'd0, 4'd0,  4'd0}, 1'b1, START_VIEW},
      '{'{MODE_DIGIT,  16'hFFFF,  2'd0, 4'd15, 4'd0}, 1'b1, START_VIEW},
      '{'{MODE_DIGIT,  16'h0000,  2'd3, 4'd0,  4'hF}, 1'b1, START_VIEW},
      '{'{MODE_DIGIT,  16'h0000,  2'd1, 4'd8,  4'd0}, 1'b1, START_VIEW},
      '{'{MODE_POINT,  16'h0000,  2'd0, 4'd0,  4'hF}, 1'b1, START_VIEW},
      '{'{MODE_POINT,  16'h0000,  2'd0, 4'd0,  4'd0}, 1'b1, START_VIEW},
      '{'{MODE_POINT,  16'h0000,  2'd0, 4'd0,  4'd3}, 1'b1, START_VIEW},
      '{'{MODE_POINT,  16'h0000,  2'd0, 4'd0,  4'd4}, 1'b1, START_VIEW},
      '{'{MODE_POINT,  16'h0000,  2'd0, 4'd0,  4'd7}, 1'b1, START_VIEW},
      '{'{MODE_POINT,  16'h0000,  2'd0, 4'd0,  4'h8}, 1'b1, START_VIEW},
      '{'{MODE_POINT,  16'h0000,  2'd0, 4'd0,  4'hE}, 1'b1, START_VIEW},
      '{'{MODE_POINT,  16'h0000,  2'd0, 4'd0,  4'd2}, 1'b1, START_VIEW},
      '{'{MODE_TICK,   16'hA5A5,  2'd2, 4'd9,  4'd5}, 1'b1, START_VIEW},
      '{'{MODE_TICK,   16'h5A5A,  2'd1, 4'd6,  4'hA}, 1'b0, NO_VIEW},
      '{'{MODE_TICK,   16'h0000,  2'd0, 4'd0,  4'd0}, 1'b0, NO_VIEW},
      '{'{MODE_TICK,   16'hFFFF,  2'd3, 4'hF,  4'hF}, 1'b0, NO_VIEW},
      '{'{MODE_TICK,   16'h0000,  2'd0, 4'd0,  4'd0}, 1'b0, NO_VIEW},
      '{'{MODE_TICK,   16'h0000,  2'd0, 4'd0,  4'd0}, 1'b0, NO_VIEW}
    };
    // brightness with bit 7 set, below and above the clamp; top 0, 1 and 255;
    // the short top right after 255 leaves the counter above top
    pct_set = '{8'd30, 8'd0, 8'hFF, 8'd100, 8'd4,   8'd5, 8'd101, 8'd50, 8'd200, 8'd75};
    top_set = '{8'd49, 8'd1, 8'd0,  8'd3,   8'd255, 8'd2, 8'd7,   8'd20, 8'd49,  8'd5};

    for (int i = 0; i < DIGITS; i++) shown_codes[i] = '0;
    scan_pos  = '0;
    point_idx = POINT_OFF;
    tick_cnt  = '0;
    seg_latch = SEG_ALL_OFF;
    en_latch  = ENABLE_RESET;
    pct_reg   = '0;
    top_reg   = TOP_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rows on the reset settings
    for (int i = 0; i < DIR_ROWS; i++)
      offer_request(plan[i].req, plan[i].typed, plan[i].want);
    drain_results();

    // One random phase on the reset settings, then one per setting pair
    for (int ph = -1; ph < SETTINGS_N; ph++) begin
      if (ph >= 0) write_settings(pct_set[ph], top_set[ph]);
      if (ph == SETTINGS_N - 1) calm = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++)
        offer_request(random_request(), 1'b0, NO_VIEW);
      drain_results();
    end

    $display("covered %0d scan ticks and %0d content writes over %0d settings",
             n_ticks, n_writes, SETTINGS_N + 1);
    $display("display advanced %0d times, %0d results compared", n_scans, checked);
    if (errors == 0) begin
      $display("multiplexed_seven_segment_driver_unit: match");
    end else begin
      $display("multiplexed_seven_segment_driver_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mssd_pkg.sv
hw/rtl/multiplexed_seven_segment_driver_unit.sv
tb/tb_multiplexed_seven_segment_driver_unit.sv
